// File: rtl/alt_pkg.sv
// Shared types and constants of the allocation lifetime tracker.
package alt_pkg;

   // Raw command codes on the request port.
   localparam logic [2:0] CMD_CREATE  = 3'd0;
   localparam logic [2:0] CMD_DESTROY = 3'd1;
   localparam logic [2:0] CMD_MIGRATE = 3'd2;
   localparam logic [2:0] CMD_QUERY   = 3'd4;
   localparam logic [2:0] CMD_CLEAR   = 3'd5;

   // Result kinds.
   localparam logic [2:0] REC_NONE    = 3'd0;
   localparam logic [2:0] REC_ALLOC   = 3'd1;
   localparam logic [2:0] REC_FREE    = 3'd2;
   localparam logic [2:0] REC_UNKNOWN = 3'd3;
   localparam logic [2:0] REC_FULL    = 3'd4;

   // Largest live count that the result can report.
   localparam int unsigned LIVE_REPORT_MAX = 127;

   // Classified operation handed from the front to the back.
   typedef enum logic [2:0] {
      OP_CREATE,
      OP_DESTROY,
      OP_MIGRATE,
      OP_OTHER,
      OP_QUERY,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] key;
      logic [63:0] ts;
      logic [47:0] size;
      logic [2:0]  tier;
      logic [31:0] pid;
   } item_type;

   typedef struct packed {
      logic [2:0]  rec_kind;
      logic        found;
      logic [2:0]  tier;
      logic [47:0] size;
      logic [31:0] pid;
      logic [63:0] alloc_time;
      logic [63:0] lifetime;
      logic [6:0]  live_count;
      logic [63:0] live_bytes;
      logic [63:0] peak_live;
      logic [31:0] misorder;
      logic [31:0] events;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_READ,
      ST_EXEC,
      ST_DONE
   } back_state_type;

endpackage

// File: rtl/alt_front.sv
// Front end: accepts requests, classifies the command and queues them.
module alt_front
   import alt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  cmd,
   input  logic [63:0] obj_key,
   input  logic [63:0] timestamp,
   input  logic [47:0] obj_size,
   input  logic [2:0]  tier,
   input  logic [31:0] proc_id,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   item_type   item_in;
   logic       do_push;
   logic       do_pop;

   // Map the raw command onto an operation; unused codes act as other events.
   always_comb begin
      item_in.key  = obj_key;
      item_in.ts   = timestamp;
      item_in.size = obj_size;
      item_in.tier = tier;
      item_in.pid  = proc_id;
      unique case (cmd)
         CMD_CREATE:  item_in.op = OP_CREATE;
         CMD_DESTROY: item_in.op = OP_DESTROY;
         CMD_MIGRATE: item_in.op = OP_MIGRATE;
         CMD_QUERY:   item_in.op = OP_QUERY;
         CMD_CLEAR:   item_in.op = OP_CLEAR;
         default:     item_in.op = OP_OTHER;
      endcase
   end

   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   // Two-entry request queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) slot_ff[wr_ptr_ff] <= item_in;
   end

endmodule

// File: rtl/alt_back.sv
// Back end: key match, entry table, statistics and the result register.
module alt_back
   import alt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   input  logic [2:0] ram_tier_code,
   output logic       res_valid,
   output result_type res,
   input  logic       res_pop
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   back_state_type state_ff, state_in;
   item_type       item_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [63:0]    key_ff [TABLE_ENTRIES];
   logic [47:0]    mem_size [TABLE_ENTRIES];
   logic [63:0]    mem_time [TABLE_ENTRIES];
   logic [2:0]     mem_tier [TABLE_ENTRIES];
   logic [31:0]    mem_pid  [TABLE_ENTRIES];
   logic [47:0]    rd_size_ff;
   logic [63:0]    rd_time_ff;
   logic [2:0]     rd_tier_ff;
   logic [31:0]    rd_pid_ff;

   logic           hit_ff, hit_in;
   logic           room_ff, room_in;
   logic [IW-1:0]  slot_ff, slot_in;
   logic [IW-1:0]  hit_idx, free_idx;

   logic [63:0]    newest_ff, newest_in;
   logic [63:0]    live_ff, live_in;
   logic [63:0]    peak_ff, peak_in;
   logic [31:0]    mis_ff, mis_in;
   logic [31:0]    events_ff, events_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   result_type     pend_ff, pend_in;
   result_type     res_ff, res_in;
   logic           res_valid_ff, res_valid_in;

   logic           we_entry, we_tier;
   logic [2:0]     wr_tier;
   logic [64:0]    add_sum;
   logic [32:0]    mis_sum;
   logic           ooo, unknown;
   logic           counted;

   // Parallel key match and lowest free slot, both priority encoded.
   always_comb begin
      hit_in   = 1'b0;
      room_in  = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == item_ff.key) begin
            hit_in  = 1'b1;
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            room_in  = 1'b1;
            free_idx = IW'(i);
         end
      end
      slot_in = hit_in ? hit_idx : free_idx;
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      valid_in     = valid_ff;
      newest_in    = newest_ff;
      live_in      = live_ff;
      peak_in      = peak_ff;
      mis_in       = mis_ff;
      events_in    = events_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !res_pop;
      we_entry     = 1'b0;
      we_tier      = 1'b0;
      wr_tier      = item_ff.tier;
      counted      = (item_ff.op != OP_QUERY) && (item_ff.op != OP_CLEAR);
      ooo          = counted && (item_ff.ts < newest_ff);
      unknown      = (item_ff.op == OP_DESTROY) && !hit_ff;
      add_sum      = {1'b0, live_ff} + 65'(item_ff.size);
      mis_sum      = {1'b0, mis_ff} + 33'(ooo) + 33'(unknown);
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC: begin
            pend_in  = '0;
            state_in = ST_DONE;
            // Event and ordering statistics.
            if (counted) begin
               if (events_ff != '1) events_in = events_ff + 32'd1;
               if (!ooo) newest_in = item_ff.ts;
               mis_in = mis_sum[32] ? '1 : mis_sum[31:0];
            end
            unique case (item_ff.op)
               OP_CREATE: begin
                  if (room_ff || hit_ff) begin
                     we_entry          = 1'b1;
                     valid_in[slot_ff] = 1'b1;
                     if (!hit_ff) cnt_in = cnt_ff + CW'(1);
                     live_in            = add_sum[64] ? '1 : add_sum[63:0];
                     pend_in.rec_kind   = REC_ALLOC;
                     pend_in.tier       = item_ff.tier;
                     pend_in.size       = item_ff.size;
                     pend_in.pid        = item_ff.pid;
                     pend_in.alloc_time = item_ff.ts;
                  end else begin
                     pend_in.rec_kind = REC_FULL;
                  end
               end
               OP_DESTROY: begin
                  if (hit_ff) begin
                     valid_in[slot_ff]  = 1'b0;
                     cnt_in             = cnt_ff - CW'(1);
                     live_in            = (live_ff >= 64'(rd_size_ff)) ?
                                          live_ff - 64'(rd_size_ff) : '0;
                     pend_in.rec_kind   = REC_FREE;
                     pend_in.found      = 1'b1;
                     pend_in.tier       = rd_tier_ff;
                     pend_in.size       = rd_size_ff;
                     pend_in.pid        = rd_pid_ff;
                     pend_in.alloc_time = rd_time_ff;
                     pend_in.lifetime   = (item_ff.ts >= rd_time_ff) ?
                                          item_ff.ts - rd_time_ff : '0;
                  end else begin
                     pend_in.rec_kind = REC_UNKNOWN;
                  end
               end
               OP_MIGRATE: begin
                  if (hit_ff) begin
                     we_tier            = 1'b1;
                     wr_tier            = ram_tier_code;
                     pend_in.found      = 1'b1;
                     pend_in.tier       = ram_tier_code;
                     pend_in.size       = rd_size_ff;
                     pend_in.pid        = rd_pid_ff;
                     pend_in.alloc_time = rd_time_ff;
                  end
               end
               OP_QUERY: begin
                  if (hit_ff) begin
                     pend_in.found      = 1'b1;
                     pend_in.tier       = rd_tier_ff;
                     pend_in.size       = rd_size_ff;
                     pend_in.pid        = rd_pid_ff;
                     pend_in.alloc_time = rd_time_ff;
                  end
               end
               OP_CLEAR: begin
                  valid_in  = '0;
                  cnt_in    = '0;
                  newest_in = '0;
                  live_in   = '0;
                  peak_in   = '0;
                  mis_in    = '0;
                  events_in = '0;
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            // Peak follows the live total; load the result once the slot is free.
            if (!res_valid_ff || res_pop) begin
               peak_in            = (live_ff > peak_ff) ? live_ff : peak_ff;
               res_in             = pend_ff;
               res_in.live_count  = (32'(cnt_ff) > 32'(LIVE_REPORT_MAX)) ?
                                    7'(LIVE_REPORT_MAX) : 7'(cnt_ff);
               res_in.live_bytes  = live_ff;
               res_in.peak_live   = peak_in;
               res_in.misorder    = mis_ff;
               res_in.events      = events_ff;
               res_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         newest_ff    <= '0;
         live_ff      <= '0;
         peak_ff      <= '0;
         mis_ff       <= '0;
         events_ff    <= '0;
         cnt_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         newest_ff    <= newest_in;
         live_ff      <= live_in;
         peak_ff      <= peak_in;
         mis_ff       <= mis_in;
         events_ff    <= events_in;
         cnt_ff       <= cnt_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // Payload registers, key store and match results.
   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_item;
      if (state_ff == ST_MATCH) begin
         hit_ff  <= hit_in;
         room_ff <= room_in;
         slot_ff <= slot_in;
      end
      if (we_entry) key_ff[slot_ff] <= item_ff.key;
      pend_ff <= pend_in;
      res_ff  <= res_in;
   end

   // Entry payload memory with a registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_size_ff <= mem_size[slot_ff];
         rd_time_ff <= mem_time[slot_ff];
         rd_tier_ff <= mem_tier[slot_ff];
         rd_pid_ff  <= mem_pid[slot_ff];
      end
      if (we_entry) begin
         mem_size[slot_ff] <= item_ff.size;
         mem_time[slot_ff] <= item_ff.ts;
         mem_pid[slot_ff]  <= item_ff.pid;
      end
      if (we_entry || we_tier) mem_tier[slot_ff] <= wr_tier;
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

// File: rtl/allocation_lifetime_tracker.sv
// Top level of the allocation lifetime tracker.
//
// Requests enter through a queue-style port: an event is taken at a clock
// edge with req_push high and req_full low. A two-entry request queue lets
// the sender keep pushing while the back end works or a result waits.
// Each request produces exactly one result, shown on the rsp_ ports while
// rsp_empty is low and taken with rsp_pop.
// The back end handles one request at a time in five steps: dequeue, key
// match across the whole table, payload memory read, update, and result
// load. No new request is popped before the last result is loaded.
// If the receiver stalls, the finished result holds and the back end waits;
// the request queue fills and then raises req_full.
// The csr_ port holds ram_tier_code at byte address 0; write it only while
// the block is idle. Synchronous reset empties the table, zeroes all
// statistics and the tier register, and drops any queued requests.
module allocation_lifetime_tracker
   import alt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_cmd,
   input  logic [63:0] req_obj_key,
   input  logic [63:0] req_timestamp,
   input  logic [47:0] req_obj_size,
   input  logic [2:0]  req_tier,
   input  logic [31:0] req_proc_id,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_rec_kind,
   output logic        rsp_found,
   output logic [2:0]  rsp_entry_tier,
   output logic [47:0] rsp_entry_size,
   output logic [31:0] rsp_entry_process,
   output logic [63:0] rsp_entry_alloc_time,
   output logic [63:0] rsp_lifetime,
   output logic [6:0]  rsp_live_count,
   output logic [63:0] rsp_live_bytes,
   output logic [63:0] rsp_peak_live_bytes,
   output logic [31:0] rsp_misorder_count,
   output logic [31:0] rsp_event_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       q_valid;
   item_type   q_item;
   logic       q_pop;
   logic       res_valid;
   result_type res;
   logic [2:0] ram_tier_code_ff;

   // Configuration register.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ram_tier_code_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         ram_tier_code_ff <= csr_pwdata[2:0];
      end
   end
   assign csr_prdata = csr_paddr[2] ? '0 : {29'd0, ram_tier_code_ff};

   alt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .cmd        (req_cmd),
      .obj_key    (req_obj_key),
      .timestamp  (req_timestamp),
      .obj_size   (req_obj_size),
      .tier       (req_tier),
      .proc_id    (req_proc_id),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   alt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .ram_tier_code (ram_tier_code_ff),
      .res_valid     (res_valid),
      .res           (res),
      .res_pop       (rsp_pop)
   );

   // Result ports.
   assign rsp_empty            = !res_valid;
   assign rsp_rec_kind         = res.rec_kind;
   assign rsp_found            = res.found;
   assign rsp_entry_tier       = res.tier;
   assign rsp_entry_size       = res.size;
   assign rsp_entry_process    = res.pid;
   assign rsp_entry_alloc_time = res.alloc_time;
   assign rsp_lifetime         = res.lifetime;
   assign rsp_live_count       = res.live_count;
   assign rsp_live_bytes       = res.live_bytes;
   assign rsp_peak_live_bytes  = res.peak_live;
   assign rsp_misorder_count   = res.misorder;
   assign rsp_event_count      = res.events;

   // The live total never exceeds the reported peak.
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_live_bytes <= rsp_peak_live_bytes)
      else $error("live bytes above peak");

   // The live count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> 32'(rsp_live_count) <= 32'(TABLE_ENTRIES))
      else $error("live count above table size");

   // A recorded free always reports a hit.
   a_free_found: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_rec_kind == REC_FREE) |-> rsp_found)
      else $error("free without hit");

   // Every result other than a recorded free reports no lifetime.
   a_life_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_rec_kind != REC_FREE) |-> rsp_lifetime == '0)
      else $error("lifetime outside a free");

endmodule
